@@ hw/rtl/quoted_argument_tokenizer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the quoted argument tokenizer
// Checks are clocked on clock; the first form is quiet during reset.
// ----------------------------------------------------------------------------
`ifndef QUOTED_ARGUMENT_TOKENIZER_TOP_MACROS_SVH
`define QUOTED_ARGUMENT_TOKENIZER_TOP_MACROS_SVH
`ifndef SYNTH
`define QAT_ASSERT(lbl, prop) lbl: assert property (@(posedge clock) disable iff (reset) prop) \
   else $error("qat assertion failed");
`define QAT_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clock) prop) \
   else $error("qat assertion failed");
`else
`define QAT_ASSERT(lbl, prop)
`define QAT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ hw/rtl/qat_pkg.sv @@
// ----------------------------------------------------------------------------
// qat_pkg
// Types, character codes and helper functions shared by the tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qat_pkg;

   localparam int COUNT_BITS  = 16;
   localparam int TOTAL_W     = 16;
   localparam int FIFO_DEPTH  = 4;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_BEL    = 8'h07;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LC_A   = 8'h61;
   localparam logic [7:0] CH_LC_B   = 8'h62;
   localparam logic [7:0] CH_LC_F   = 8'h66;
   localparam logic [7:0] CH_LC_N   = 8'h6E;
   localparam logic [7:0] CH_LC_R   = 8'h72;
   localparam logic [7:0] CH_LC_T   = 8'h74;
   localparam logic [7:0] CH_LC_V   = 8'h76;

   typedef enum logic [2:0] {
      PH_BETWEEN  = 3'd0,
      PH_TOKEN    = 3'd1,
      PH_BARE_ESC = 3'd2,
      PH_SQ       = 3'd3,
      PH_SQ_ESC   = 3'd4,
      PH_DQ       = 3'd5,
      PH_DQ_ESC   = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      K_BYTE = 2'd0,
      K_END  = 2'd1,
      K_OK   = 2'd2,
      K_ERR  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         out_char;
      logic [TOTAL_W-1:0] token_total;
      logic               last_of_run;
   } rsp_type;

   // Up to two results caused by one request, in order.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } parse_out_type;

   function automatic logic is_blank(input logic [7:0] ch);
      return ch inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
   endfunction

   function automatic logic [7:0] translate(input logic [7:0] ch);
      logic [7:0] res;
      case (ch)
         CH_LC_A: res = CH_BEL;
         CH_LC_B: res = CH_BS;
         CH_LC_T: res = CH_TAB;
         CH_LC_N: res = CH_LF;
         CH_LC_V: res = CH_VT;
         CH_LC_F: res = CH_FF;
         CH_LC_R: res = CH_CR;
         default: res = ch;
      endcase
      return res;
   endfunction

endpackage

@@ hw/rtl/qat_parse.sv @@
// ----------------------------------------------------------------------------
// qat_parse
// Parser state and token counter; decodes one byte into up to two results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quoted_argument_tokenizer_top_macros.svh"

module qat_parse
   import qat_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic [7:0]    in_char,
   output parse_out_type result
);

   localparam int WIDE_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   phase_type             phase_ff, phase_in;
   logic [COUNT_BITS-1:0] count_ff, count_in, count_after;
   logic [WIDE_W-1:0]     count_wide;
   logic [TOTAL_W-1:0]    total;
   logic [1:0]            n;
   kind_type              k0, k1;
   logic [7:0]            c0, c1;
   logic                  inc, clr, use_bare;

   always_comb begin
      n        = 2'd0;
      k0       = K_BYTE;
      k1       = K_BYTE;
      c0       = CH_NUL;
      c1       = CH_NUL;
      inc      = 1'b0;
      clr      = 1'b0;
      use_bare = 1'b0;
      phase_in = phase_ff;
      unique case (phase_ff) inside
         PH_TOKEN: begin
            use_bare = 1'b1;
         end
         PH_BARE_ESC: begin
            if (in_char == CH_NUL) begin
               inc = 1'b1; clr = 1'b1; n = 2'd2;
               k0 = K_END; k1 = K_OK;
               phase_in = PH_BETWEEN;
            end else begin
               n = 2'd1; c0 = in_char;
               phase_in = PH_TOKEN;
            end
         end
         PH_SQ, PH_DQ: begin
            if (in_char == CH_NUL) begin
               clr = 1'b1; n = 2'd1; k0 = K_ERR;
               phase_in = PH_BETWEEN;
            end else if ((phase_ff == PH_SQ && in_char == CH_SQUOTE) ||
                         (phase_ff == PH_DQ && in_char == CH_DQUOTE)) begin
               phase_in = PH_TOKEN;
            end else if (in_char == CH_BSLASH) begin
               phase_in = (phase_ff == PH_SQ) ? PH_SQ_ESC : PH_DQ_ESC;
            end else begin
               n = 2'd1; c0 = in_char;
            end
         end
         PH_SQ_ESC: begin
            if (in_char == CH_NUL) begin
               clr = 1'b1; n = 2'd1; k0 = K_ERR;
               phase_in = PH_BETWEEN;
            end else begin
               phase_in = PH_SQ;
               // Only quote and backslash are real escapes; otherwise the
               // backslash is kept in front of the byte.
               if (in_char == CH_BSLASH || in_char == CH_SQUOTE) begin
                  n = 2'd1; c0 = in_char;
               end else begin
                  n = 2'd2; c0 = CH_BSLASH; c1 = in_char;
               end
            end
         end
         PH_DQ_ESC: begin
            if (in_char == CH_NUL) begin
               clr = 1'b1; n = 2'd1; k0 = K_ERR;
               phase_in = PH_BETWEEN;
            end else begin
               n = 2'd1; c0 = translate(in_char);
               phase_in = PH_DQ;
            end
         end
         default: begin
            // Between tokens, and the unused phase code.
            phase_in = PH_BETWEEN;
            if (in_char == CH_NUL) begin
               clr = 1'b1; n = 2'd1; k0 = K_OK;
            end else if (!is_blank(in_char)) begin
               use_bare = 1'b1;
            end
         end
      endcase

      if (use_bare) begin
         if (in_char == CH_NUL) begin
            inc = 1'b1; clr = 1'b1; n = 2'd2;
            k0 = K_END; k1 = K_OK;
            phase_in = PH_BETWEEN;
         end else if (in_char == CH_BSLASH) begin
            phase_in = PH_BARE_ESC;
         end else if (in_char == CH_SQUOTE) begin
            phase_in = PH_SQ;
         end else if (in_char == CH_DQUOTE) begin
            phase_in = PH_DQ;
         end else if (is_blank(in_char) || in_char == CH_BS) begin
            inc = 1'b1; n = 2'd1; k0 = K_END;
            phase_in = PH_BETWEEN;
         end else begin
            n = 2'd1; c0 = in_char;
            phase_in = PH_TOKEN;
         end
      end
   end

   always_comb begin
      count_after = (inc && count_ff != CNT_MAX) ? count_ff + 1'b1 : count_ff;
      count_in    = clr ? '0 : count_after;
      count_wide  = WIDE_W'(count_after);
      total       = (count_wide > WIDE_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                      : count_wide[TOTAL_W-1:0];
      result.count              = n;
      result.first.kind         = k0;
      result.first.out_char     = c0;
      result.first.token_total  = total;
      result.first.last_of_run  = (n == 2'd1);
      result.second.kind        = k1;
      result.second.out_char    = c1;
      result.second.token_total = total;
      result.second.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BETWEEN;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // A finished or failed string leaves the parser ready for a fresh one.
   `QAT_ASSERT(a_finish_resets, (step && clr) |=> (phase_ff == PH_BETWEEN && count_ff == '0))
   // Token bytes only ever leave from a byte that is not the string end.
   `QAT_ASSERT(a_no_byte_on_end, (step && in_char == CH_NUL) |-> (n == 2'd0 || k0 != K_BYTE))
   // The counter never moves without a request.
   `QAT_ASSERT(a_hold_idle, !$past(step) |-> ($stable(count_ff) && $stable(phase_ff)))

endmodule

@@ hw/rtl/qat_rsp_fifo.sv @@
// ----------------------------------------------------------------------------
// qat_rsp_fifo
// Small result queue that takes up to two results a cycle and gives one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quoted_argument_tokenizer_top_macros.svh"

module qat_rsp_fifo
   import qat_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  parse_out_type push_data,
   output logic          space,
   input  logic          pop,
   output rsp_type       head,
   output logic          head_valid
);

   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

   rsp_type            mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [1:0]         push_count;

   always_comb begin
      push_count = push ? push_data.count : 2'd0;
      wr_next    = wr_ptr_ff + 1'b1;
      wr_ptr_in  = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in  = rd_ptr_ff + PTR_W'(pop);
      fill_in    = fill_ff + FILL_W'(push_count) - FILL_W'(pop);
      // Room for a request that may leave two results.
      space      = (fill_ff <= FILL_W'(FIFO_DEPTH - 2));
      head_valid = (fill_ff != '0);
      head       = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data.first;
      end
      if (push && push_count == 2'd2) begin
         mem_ff[wr_next] <= push_data.second;
      end
   end

   `QAT_ASSERT(a_fill_bound, fill_ff <= FILL_W'(FIFO_DEPTH))
   `QAT_ASSERT(a_no_overflow, push |-> space)
   `QAT_ASSERT(a_fill_track, (!pop && push_count == 2'd0) |=> $stable(fill_ff))

endmodule

@@ hw/rtl/quoted_argument_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_top
// Shell-style argument tokenizer with quotes, escapes and a token count.
// ----------------------------------------------------------------------------
//  channel   ports     direction  content
//  request   req_*     in         in_char, one byte of the string
//  response  rsp_*     out        kind, out_char, token_total, last_of_run
//
// A request is decoded in the cycle it is accepted, one request per cycle while req_ready is high.
// Its results leave a four-entry queue one per cycle while rsp_ready is high, from the next cycle on.
// A request that yields two results therefore leaves as two separate responses;
// req_ready is low while the queue cannot take two more results.
// Reset clears the pointers, fill count and parser state; the queue memory gets no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quoted_argument_tokenizer_top
   import qat_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_in_char,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_out_char,
   output logic [TOTAL_W-1:0]  rsp_token_total,
   output logic                rsp_last_of_run
);

   parse_out_type parsed;
   rsp_type       head;
   logic          step, pop, space;

   assign req_ready = space;
   assign step      = req_valid && space;
   assign pop       = rsp_valid && rsp_ready;

   qat_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_char (req_in_char),
      .result  (parsed)
   );

   qat_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (step),
      .push_data  (parsed),
      .space      (space),
      .pop        (pop),
      .head       (head),
      .head_valid (rsp_valid)
   );

   assign rsp_kind        = head.kind;
   assign rsp_out_char    = head.out_char;
   assign rsp_token_total = head.token_total;
   assign rsp_last_of_run = head.last_of_run;

endmodule
